// ===== rtl/rgba16_to_netpbm_binary_packer_top_defines.svh =====
// assertion macros for the netpbm packer
`ifndef RGBA16_TO_NETPBM_BINARY_PACKER_TOP_DEFINES_SVH
`define RGBA16_TO_NETPBM_BINARY_PACKER_TOP_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define RNP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define RNP_ASSERT_NEVER(label, cond, msg) \
  `RNP_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/rnp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rnp_pkg;

  // output format selected by the mode register
  typedef enum logic [1:0] {
    MODE_MONO = 2'd0,
    MODE_GREY = 2'd1,
    MODE_RGB  = 2'd2,
    MODE_RGBA = 2'd3
  } mode_e;

  // configuration register indexes
  localparam logic [1:0] CFG_IDX_MODE  = 2'd0;
  localparam logic [1:0] CFG_IDX_DEPTH = 2'd1;
  localparam logic [1:0] CFG_IDX_WIDTH = 2'd2;

  localparam logic [4:0]  DEPTH_MAX     = 5'd16;
  localparam logic [4:0]  DEPTH_MIN     = 5'd1;
  localparam logic [4:0]  DEPTH_NARROW  = 5'd8;
  localparam logic [15:0] WIDTH_RESET   = 16'd1;
  localparam logic [7:0]  MONO_BYTE_SET = 8'hFF;

  // job queue between the front and back parts
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [15:0] red_sample;
    logic [15:0] green_sample;
    logic [15:0] blue_sample;
    logic [15:0] alpha_sample;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_pixel;
  } result_t;

  typedef struct packed {
    mode_e       output_mode;
    logic [4:0]  depth_bits;
    logic [15:0] row_width;
  } cfg_t;

  // one queued pixel: truncated channels, index of the last channel, two-byte flag
  typedef struct packed {
    logic [3:0][15:0] kept;
    logic [1:0]       last_chan;
    logic             wide;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rgba16_to_netpbm_binary_packer_top.sv =====
// a pixel's first byte is written into the queue, then into the output register
// throughput: one pixel per cycle in mono mode while the queue is not full, else
//   1, 2, 3, 4, 6 or 8 bytes a pixel go in turn via the single byte-wide register
// a two-word queue lets the pixel side run ahead of the byte side
// reset is asynchronous and active low: mode mono, depth 16, row width 1,
//   column zero, partial mono byte all ones, queue and output empty
`timescale 1ns / 1ps
`default_nettype none
`include "rgba16_to_netpbm_binary_packer_top_defines.svh"

module rgba16_to_netpbm_binary_packer_top import rnp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire pixel_t      in_pixel_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output result_t          out_result_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  cfg_t       cfg_q, cfg_d;
  fifo_stat_t fifo_stat;
  job_t       push_job, head_job;
  logic       push, pop, accept;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_IDX_MODE:  cfg_d.output_mode = mode_e'(cfg_data_i[1:0]);
        CFG_IDX_DEPTH: cfg_d.depth_bits  = cfg_data_i[4:0];
        CFG_IDX_WIDTH: cfg_d.row_width   = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.output_mode <= MODE_MONO;
      cfg_q.depth_bits  <= DEPTH_MAX;
      cfg_q.row_width   <= WIDTH_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pixel side
  assign in_stall_o = fifo_stat.full;
  assign accept     = in_valid_i && !in_stall_o;

  rnp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .pixel_i  (in_pixel_i),
    .cfg_i    (cfg_q),
    .push_o   (push),
    .job_o    (push_job)
  );

  rnp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (fifo_stat)
  );

  // byte side
  rnp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .stat_i      (fifo_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_result_o)
  );

  // checks
  `RNP_ASSERT_NEVER(a_no_overflow, push && fifo_stat.full && !pop, "queue written while full")
  `RNP_ASSERT_NEVER(a_no_underflow, pop && fifo_stat.empty, "queue read while empty")
  `RNP_ASSERT(a_colour_pushes, (accept && cfg_q.output_mode != MODE_MONO) |-> push, "colour pixel not queued")
  `RNP_ASSERT(a_push_fills, (push && !pop) |=> !fifo_stat.empty, "queued word lost")

endmodule

`default_nettype wire

// ===== rtl/rnp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rnp_front import rnp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   accept_i,
  input  wire pixel_t pixel_i,
  input  wire cfg_t   cfg_i,
  output logic        push_o,
  output job_t        job_o
);

  logic [15:0] col_q, col_d;
  logic [7:0]  pack_q, pack_d;

  logic [15:0] width_eff;
  logic        row_end;
  logic [7:0]  pack_base;
  logic [7:0]  pack_next;
  logic        mono_emit;
  logic [4:0]  depth_eff;
  logic [3:0]  shamt;
  logic        is_mono;

  assign is_mono = (cfg_i.output_mode == MODE_MONO);

  // mono bit packing
  assign width_eff = (cfg_i.row_width == '0) ? WIDTH_RESET : cfg_i.row_width;
  assign row_end   = ({1'b0, col_q} + 17'd1) >= {1'b0, width_eff};
  assign pack_base = (col_q[2:0] == 3'd0) ? MONO_BYTE_SET : pack_q;
  assign pack_next = pixel_i.red_sample[15] ? (pack_base & ~(8'h80 >> col_q[2:0]))
                                             : pack_base;
  assign mono_emit = (col_q[2:0] == 3'd7) || row_end;

  // depth clamp and truncating shift
  always_comb begin
    depth_eff = cfg_i.depth_bits;
    if (cfg_i.depth_bits < DEPTH_MIN) begin
      depth_eff = DEPTH_MIN;
    end else if (cfg_i.depth_bits > DEPTH_MAX) begin
      depth_eff = DEPTH_MAX;
    end
  end
  assign shamt = 4'(DEPTH_MAX - depth_eff);

  // build the queued word
  always_comb begin
    job_o = '0;
    if (is_mono) begin
      job_o.kept[0][7:0] = pack_next;
    end else begin
      job_o.kept[0] = pixel_i.red_sample >> shamt;
      job_o.kept[1] = pixel_i.green_sample >> shamt;
      job_o.kept[2] = pixel_i.blue_sample >> shamt;
      job_o.kept[3] = pixel_i.alpha_sample >> shamt;
      job_o.wide    = depth_eff > DEPTH_NARROW;
      unique case (cfg_i.output_mode)
        MODE_GREY: job_o.last_chan = 2'd0;
        MODE_RGB:  job_o.last_chan = 2'd2;
        MODE_RGBA: job_o.last_chan = 2'd3;
        default:   job_o.last_chan = 2'd0;
      endcase
    end
  end

  assign push_o = accept_i && (!is_mono || mono_emit);

  // column and partial byte update
  always_comb begin
    col_d  = col_q;
    pack_d = pack_q;
    if (accept_i && is_mono) begin
      col_d  = row_end ? '0 : col_q + 16'd1;
      pack_d = mono_emit ? MONO_BYTE_SET : pack_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      pack_q <= MONO_BYTE_SET;
    end else begin
      col_q  <= col_d;
      pack_q <= pack_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rnp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rnp_fifo import rnp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  input  wire logic pop_i,
  output job_t       job_o,
  output fifo_stat_t stat_o
);

  job_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign job_o        = mem_q[rd_q];

  // pointer and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rnp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rnp_back import rnp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire job_t       job_i,
  input  wire fifo_stat_t stat_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output result_t         out_o
);

  logic [2:0]  idx_q, idx_d;
  logic        valid_q, valid_d;
  result_t     res_q, res_d;

  logic        load;
  logic        have_job;
  logic [1:0]  chan;
  logic        hi;
  logic [15:0] sample;
  logic [2:0]  last_idx;
  logic        is_last;

  // byte selection within the current word
  assign chan     = job_i.wide ? idx_q[2:1] : idx_q[1:0];
  assign hi       = job_i.wide && !idx_q[0];
  assign sample   = job_i.kept[chan];
  assign last_idx = job_i.wide ? {job_i.last_chan, 1'b1} : {1'b0, job_i.last_chan};
  assign is_last  = (idx_q == last_idx);

  assign have_job = !stat_i.empty;
  assign load     = !valid_q || !out_stall_i;
  assign pop_o    = have_job && load && is_last;

  // output register and byte counter
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    res_d   = res_q;
    if (load) begin
      valid_d = have_job;
      if (have_job) begin
        res_d.out_byte      = hi ? sample[15:8] : sample[7:0];
        res_d.last_of_pixel = is_last;
        idx_d               = is_last ? '0 : idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

`default_nettype wire
